[src/fifo_queue_with_search_assert.svh]
// ----------------------------------------------------------------------------
// fifo queue with search: assertion macros
// shared property forms, clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// same-cycle implication
`define FQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fqs_pkg.sv]
// ----------------------------------------------------------------------------
// fqs_pkg
// types and constants shared by the fifo queue with search
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OP_W      = 2;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 3;
  localparam int POS_W     = 4;
  localparam int MAX_RES   = 16;
  localparam int MATCH_W   = $clog2(MAX_RES + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SRCH = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DEQUEUED  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_LAST
  } state_t;

  // memory port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[src/fqs_mem.sv]
// ----------------------------------------------------------------------------
// fqs_mem
// ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module fqs_mem
  import fqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  mem_ctl_t                ctl,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem_r [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/fqs_seq.sv]
// ----------------------------------------------------------------------------
// fqs_seq
// sequencer: ring pointers, shared compare unit and result register
// ----------------------------------------------------------------------------
`include "fifo_queue_with_search_assert.svh"

module fqs_seq
  import fqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  output mem_ctl_t                mem_ctl,
  output logic [AW-1:0]           mem_waddr,
  output logic signed [VAL_W-1:0] mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  logic signed [VAL_W-1:0] mem_rdata,
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_item,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_last
);

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic [AW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [AW-1:0]           scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]           iss_r, iss_nxt;
  logic [CW-1:0]           chk_r, chk_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [MATCH_W-1:0]      match_r, match_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  logic [POS_W-1:0]        pend_pos_r, pend_pos_nxt;
  logic                    out_vld_r, out_vld_nxt;
  status_t                 out_st_r, out_st_nxt;
  logic signed [VAL_W-1:0] out_item_r, out_item_nxt;
  logic [POS_W-1:0]        out_pos_r, out_pos_nxt;
  logic                    out_last_r, out_last_nxt;

  logic    accept;
  logic    q_empty;
  logic    q_full;
  logic    hit;
  logic    scan_done;
  opcode_t op;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    ring_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign op      = opcode_t'(in_opcode);
  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == CW'(DEPTH));

  // shared compare unit
  assign hit       = (mem_rdata == key_r);
  assign scan_done = (chk_r == count_r - CW'(1)) ||
                     (hit && match_r == MATCH_W'(MAX_RES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_DEQ:  if (!q_empty) state_nxt = S_DEQ;
            OP_SRCH: if (!q_empty) state_nxt = S_SCAN;
            default: ;
          endcase
        end
      end
      S_DEQ:   state_nxt = S_IDLE;
      S_SCAN:  if (scan_done) state_nxt = S_LAST;
      S_LAST:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    scan_idx_nxt = scan_idx_r;
    iss_nxt      = iss_r;
    chk_nxt      = chk_r;
    pos_nxt      = pos_r;
    match_nxt    = match_r;
    pend_vld_nxt = pend_vld_r;
    pend_pos_nxt = pend_pos_r;
    out_vld_nxt  = 1'b0;
    out_st_nxt   = ST_ENQUEUED;
    out_item_nxt = '0;
    out_pos_nxt  = '0;
    out_last_nxt = 1'b0;
    mem_ctl      = '0;
    mem_raddr    = scan_idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_ENQ: begin
              out_vld_nxt  = 1'b1;
              out_last_nxt = 1'b1;
              if (q_full) begin
                out_st_nxt = ST_OVERFLOW;
              end else begin
                out_st_nxt    = ST_ENQUEUED;
                mem_ctl.wr_en = 1'b1;
                tail_nxt      = ring_next(tail_r);
                count_nxt     = count_r + CW'(1);
              end
            end
            OP_DEQ: begin
              if (q_empty) begin
                out_vld_nxt  = 1'b1;
                out_last_nxt = 1'b1;
                out_st_nxt   = ST_UNDERFLOW;
              end else begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = head_r;
              end
            end
            OP_SRCH: begin
              if (q_empty) begin
                out_vld_nxt  = 1'b1;
                out_last_nxt = 1'b1;
                out_st_nxt   = ST_EMPTY;
              end else begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = head_r;
                key_nxt       = in_value;
                scan_idx_nxt  = ring_next(head_r);
                iss_nxt       = CW'(1);
                chk_nxt       = '0;
                pos_nxt       = '0;
                match_nxt     = '0;
                pend_vld_nxt  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEQ: begin
        out_vld_nxt  = 1'b1;
        out_last_nxt = 1'b1;
        out_st_nxt   = ST_DEQUEUED;
        out_item_nxt = mem_rdata;
        head_nxt     = ring_next(head_r);
        count_nxt    = count_r - CW'(1);
      end
      S_SCAN: begin
        if (iss_r != count_r) begin
          mem_ctl.rd_en = 1'b1;
          scan_idx_nxt  = ring_next(scan_idx_r);
          iss_nxt       = iss_r + CW'(1);
        end
        chk_nxt = chk_r + CW'(1);
        pos_nxt = pos_r + POS_W'(1);
        if (hit) begin
          match_nxt    = match_r + MATCH_W'(1);
          pend_vld_nxt = 1'b1;
          pend_pos_nxt = pos_r;
          if (pend_vld_r) begin
            out_vld_nxt = 1'b1;
            out_st_nxt  = ST_FOUND;
            out_pos_nxt = pend_pos_r;
          end
        end
      end
      S_LAST: begin
        out_vld_nxt  = 1'b1;
        out_last_nxt = 1'b1;
        if (pend_vld_r) begin
          out_st_nxt  = ST_FOUND;
          out_pos_nxt = pend_pos_r;
        end else begin
          out_st_nxt = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  assign mem_waddr = tail_r;
  assign mem_wdata = in_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    scan_idx_r <= scan_idx_nxt;
    iss_r      <= iss_nxt;
    chk_r      <= chk_nxt;
    pos_r      <= pos_nxt;
    match_r    <= match_nxt;
    pend_vld_r <= pend_vld_nxt;
    pend_pos_r <= pend_pos_nxt;
    out_st_r   <= out_st_nxt;
    out_item_r <= out_item_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_vld_r;
  assign out_status   = out_st_r;
  assign out_item     = out_item_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;

  `FQS_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(DEPTH), "fill count above depth")
  `FQS_ASSERT_NOW(a_empty_ptrs, q_empty, head_r == tail_r, "empty queue with pointers apart")
  `FQS_ASSERT_NEXT(a_enq_result, accept && op == OP_ENQ, out_valid && out_last, "enqueue without result")
  `FQS_ASSERT_NEXT(a_scan_exit, state_r == S_SCAN, state_r == S_SCAN || state_r == S_LAST, "scan left early")

endmodule

[src/fifo_queue_with_search.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// first-in first-out ring of signed 32-bit values with enqueue, dequeue and
// a sequential search that reports up to 16 matches, each by its position
// ----------------------------------------------------------------------------
// a command is transferred at a rising edge with start high and busy low.
// enqueue gives its result on the next cycle; dequeue reads the ring
// memory through its registered port and then returns the value through
// the result register. during a search one memory read is issued per cycle
// and the single compare unit checks one stored entry per cycle from head
// to tail, ending early once 16 matches are seen. results come out one per
// cycle as single-cycle strobes on out_valid and cannot be held off, so the
// receiver must take each one when it appears; the final result of every
// command carries out_last. positions count from the head, modulo 16.
// opcode 3 is taken but does nothing and gives no result.
// ----------------------------------------------------------------------------
module fifo_queue_with_search
  import fqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // command side
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  // result side, one strobe per result transfer
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic signed [VAL_W-1:0] out_item,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_last
);

  localparam int AW = $clog2(DEPTH);

  // memory port between sequencer and ring storage
  mem_ctl_t                mem_ctl;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic signed [VAL_W-1:0] mem_rdata;

  // sequencer: pointers, fill count, compare unit and result register
  fqs_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .mem_ctl      (mem_ctl),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_item     (out_item),
    .out_position (out_position),
    .out_last     (out_last)
  );

  // ring storage, contents undefined until written
  fqs_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
